@@ sv/scbst_pkg.sv @@
// ----------------------------------------------------------------------------
// scbst_pkg : shared types and constants
// Types and saturation limits for the swept circle / box slab test.
// ----------------------------------------------------------------------------
package scbst_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned NUM_W  = 33;

  localparam logic signed [WORD_W-1:0] T_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [WORD_W-1:0] T_MIN = 32'sh8000_0000;

  // Slab result for one axis
  typedef struct packed {
    logic signed [WORD_W-1:0] t_in;
    logic signed [WORD_W-1:0] t_out;
    logic                     v_neg;
  } slab_res_t;

  // Clamp a 34-bit signed value to 32 bits
  function automatic logic signed [WORD_W-1:0] sat34(input logic signed [33:0] v);
    logic signed [33:0] hi;
    logic signed [33:0] lo;
    hi = 34'sh0_7FFF_FFFF;
    lo = -34'sh0_8000_0000;
    if (v > hi) begin
      return T_MAX;
    end else if (v < lo) begin
      return T_MIN;
    end
    return v[WORD_W-1:0];
  endfunction

endpackage

@@ sv/scbst_div.sv @@
// ----------------------------------------------------------------------------
// scbst_div : pipelined restoring divider
// Unsigned magnitude division, one quotient bit per stage, with stall.
// Carries a side-band tag through the stages.
// ----------------------------------------------------------------------------
module scbst_div
  import scbst_pkg::*;
#(
  parameter int unsigned QW   = 48,
  parameter int unsigned DW   = 32,
  parameter int unsigned TAGW = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_v,
  input  logic [QW-1:0]   in_num,
  input  logic [DW-1:0]   in_den,
  input  logic [TAGW-1:0] in_tag,
  output logic            out_v,
  output logic [QW-1:0]   out_quo,
  output logic [TAGW-1:0] out_tag
);

  // stage s holds partial remainder, remaining dividend/quotient bits
  logic            v_r   [QW+1];
  logic [DW:0]     rem_r [QW+1];
  logic [QW-1:0]   q_r   [QW+1];
  logic [DW-1:0]   den_r [QW+1];
  logic [TAGW-1:0] tag_r [QW+1];

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= '0;
      q_r[0]   <= in_num;
      den_r[0] <= in_den;
      tag_r[0] <= in_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_v;
    end
  end

  for (genvar s = 0; s < QW; s++) begin : g_st
    logic [DW+1:0] sh;
    logic [DW+1:0] diff;
    assign sh   = {rem_r[s], q_r[s][QW-1]};
    assign diff = sh - {2'b00, den_r[s]};
    always_ff @(posedge clk) begin
      if (en) begin
        if (!diff[DW+1]) begin
          rem_r[s+1] <= diff[DW:0];
          q_r[s+1]   <= {q_r[s][QW-2:0], 1'b1};
        end else begin
          rem_r[s+1] <= sh[DW:0];
          q_r[s+1]   <= {q_r[s][QW-2:0], 1'b0};
        end
        den_r[s+1] <= den_r[s];
        tag_r[s+1] <= tag_r[s];
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s+1] <= 1'b0;
      end else if (en) begin
        v_r[s+1] <= v_r[s];
      end
    end
  end

  assign out_v   = v_r[QW];
  assign out_quo = q_r[QW];
  assign out_tag = tag_r[QW];

endmodule

@@ sv/swept_circle_box_slab_test.sv @@
// ----------------------------------------------------------------------------
// swept_circle_box_slab_test : swept circle against box, slab test
// Pipelined fixed-point slab intersection of a moving circle and a box.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_*: one request per accepted beat (in_valid high and
//   in_stall low at a rising edge) carrying circle, velocity and box.
//   Result channel out_*: one result per request, in order; the receiver
//   holds off with out_stall.
//   Stages in order: grown bounds, distances, the bit-per-stage dividers
//   that set the depth (one per slab bound, four in parallel), signed
//   slab times and the output register.
//   Throughput: one request per cycle unless stalled. The whole pipe, including
//   the output register, advances together; a stall on the output freezes
//   every stage and raises in_stall while the output register holds a stalled
//   result, so nothing is lost or repeated; bubbles move with the pipe.
//   Reset (rst_n low, synchronous) clears all valid bits; payload registers
//   are not reset.
//   Zero velocity gives saturated infinite slab times; quotients saturate
//   to 32 bits. A miss returns is_hit, time and normal all zero.
// ----------------------------------------------------------------------------
module swept_circle_box_slab_test
  import scbst_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_center_x,
  input  logic signed [31:0] in_center_y,
  input  logic        [30:0] in_circle_radius,
  input  logic signed [31:0] in_vel_x,
  input  logic signed [31:0] in_vel_y,
  input  logic signed [31:0] in_box_min_x,
  input  logic signed [31:0] in_box_min_y,
  input  logic signed [31:0] in_box_max_x,
  input  logic signed [31:0] in_box_max_y,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_is_hit,
  output logic signed [31:0] out_entry_time,
  output logic signed [1:0]  out_normal_x,
  output logic signed [1:0]  out_normal_y
);

  localparam int unsigned QW   = NUM_W + FRAC_BITS;  // numerator magnitude width
  // tag: per axis {zero_vel, inside, v_neg, num_sign_lo, num_sign_hi}
  localparam int unsigned TAGW = 5;

  // Whole pipe moves when the output register is free or being drained
  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // ---------------- stage 1: grown bounds ---------------------------------
  logic               s1_v_r;
  logic signed [31:0] s1_lo_r [2];
  logic signed [31:0] s1_hi_r [2];
  logic signed [31:0] s1_c_r  [2];
  logic signed [31:0] s1_vel_r[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_lo_r[0]  <= sat34(34'(in_box_min_x) - 34'(signed'({1'b0, in_circle_radius})));
      s1_hi_r[0]  <= sat34(34'(in_box_max_x) + 34'(signed'({1'b0, in_circle_radius})));
      s1_lo_r[1]  <= sat34(34'(in_box_min_y) - 34'(signed'({1'b0, in_circle_radius})));
      s1_hi_r[1]  <= sat34(34'(in_box_max_y) + 34'(signed'({1'b0, in_circle_radius})));
      s1_c_r[0]   <= in_center_x;
      s1_c_r[1]   <= in_center_y;
      s1_vel_r[0] <= in_vel_x;
      s1_vel_r[1] <= in_vel_y;
    end
  end

  // ---------------- stage 2: distances, magnitudes ------------------------
  logic               s2_v_r;
  logic [QW-1:0]      s2_nlo_r [2];
  logic [QW-1:0]      s2_nhi_r [2];
  logic [31:0]        s2_den_r [2];
  logic [TAGW-1:0]    s2_tag_r [2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en) begin
      s2_v_r <= s1_v_r;
    end
  end

  for (genvar a = 0; a < 2; a++) begin : g_ax
    logic signed [32:0] dlo;
    logic signed [32:0] dhi;
    logic [32:0]        mlo;
    logic [32:0]        mhi;
    logic               zv;
    logic               ins;
    logic               vn;
    assign dlo = 33'(s1_lo_r[a]) - 33'(s1_c_r[a]);
    assign dhi = 33'(s1_hi_r[a]) - 33'(s1_c_r[a]);
    assign mlo = dlo[32] ? 33'(-dlo) : 33'(dlo);
    assign mhi = dhi[32] ? 33'(-dhi) : 33'(dhi);
    assign zv  = (s1_vel_r[a] == '0);
    assign ins = (s1_c_r[a] >= s1_lo_r[a]) && (s1_c_r[a] <= s1_hi_r[a]);
    assign vn  = s1_vel_r[a][31];
    always_ff @(posedge clk) begin
      if (en) begin
        s2_nlo_r[a] <= {mlo, {FRAC_BITS{1'b0}}};
        s2_nhi_r[a] <= {mhi, {FRAC_BITS{1'b0}}};
        s2_den_r[a] <= vn ? 32'(-s1_vel_r[a]) : 32'(s1_vel_r[a]);
        s2_tag_r[a] <= {zv, ins, vn, dlo[32] ^ vn, dhi[32] ^ vn};
      end
    end
  end

  // ---------------- divider stages ----------------------------------------
  logic            dv     [4];
  logic [QW-1:0]   dq     [4];
  logic [TAGW-1:0] dtag   [4];

  for (genvar k = 0; k < 4; k++) begin : g_div
    scbst_div #(.QW(QW), .DW(32), .TAGW(TAGW)) u_div (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .in_v    (s2_v_r),
      .in_num  ((k % 2 == 0) ? s2_nlo_r[k/2] : s2_nhi_r[k/2]),
      .in_den  (s2_den_r[k/2]),
      .in_tag  (s2_tag_r[k/2]),
      .out_v   (dv[k]),
      .out_quo (dq[k]),
      .out_tag (dtag[k])
    );
  end

  // ---------------- stage A: signed saturated slab times ------------------
  function automatic logic signed [31:0] sgn_sat(input logic [QW-1:0] q, input logic neg);
    logic big;
    big = (q[QW-1:31] != '0);
    if (neg) begin
      if (big || (q[30:0] != '0 && q[31])) begin
        return T_MIN;
      end
      return 32'(-signed'({1'b0, q[31:0]}));
    end
    if (big || q[31]) begin
      return T_MAX;
    end
    return signed'(q[31:0]);
  endfunction

  logic      sa_v_r;
  slab_res_t sa_r [2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sa_v_r <= 1'b0;
    end else if (en) begin
      sa_v_r <= dv[0];
    end
  end

  for (genvar a = 0; a < 2; a++) begin : g_sl
    logic [TAGW-1:0]    tg;
    logic signed [31:0] ta;
    logic signed [31:0] tb;
    slab_res_t          res;
    assign tg = dtag[2*a];
    assign ta = sgn_sat(dq[2*a],   tg[1]);
    assign tb = sgn_sat(dq[2*a+1], tg[0]);
    always_comb begin
      res.v_neg = tg[2];
      if (tg[4]) begin
        res.t_in  = tg[3] ? T_MIN : T_MAX;
        res.t_out = tg[3] ? T_MAX : T_MIN;
      end else if (tg[2]) begin
        res.t_in  = tb;
        res.t_out = ta;
      end else begin
        res.t_in  = ta;
        res.t_out = tb;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sa_r[a] <= res;
      end
    end
  end

  // ---------------- output stage: combine axes ----------------------------
  logic               x_wins;
  logic signed [31:0] entry;
  logic signed [31:0] leave;
  logic               hit;

  assign x_wins = sa_r[0].t_in > sa_r[1].t_in;
  assign entry  = x_wins ? sa_r[0].t_in : sa_r[1].t_in;
  assign leave  = (sa_r[0].t_out < sa_r[1].t_out) ? sa_r[0].t_out : sa_r[1].t_out;
  assign hit    = !((entry > leave) || (sa_r[0].t_in[31] && sa_r[1].t_in[31]));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= sa_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_is_hit     <= hit;
      out_entry_time <= hit ? entry : '0;
      out_normal_x   <= (hit && x_wins)  ? (sa_r[0].v_neg ? 2'sd1 : -2'sd1) : 2'sd0;
      out_normal_y   <= (hit && !x_wins) ? (sa_r[1].v_neg ? 2'sd1 : -2'sd1) : 2'sd0;
    end
  end

endmodule

@@ tb/swept_circle_box_slab_test_checker.sv @@
// ----------------------------------------------------------------------------
// swept_circle_box_slab_test_checker : result predictor and comparator
// Watches both channels, predicts the slab test outcome of every accepted
// request and compares each accepted result against the oldest prediction.
// ----------------------------------------------------------------------------
module swept_circle_box_slab_test_checker #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [31:0] in_center_x,
  input  logic signed [31:0] in_center_y,
  input  logic        [30:0] in_circle_radius,
  input  logic signed [31:0] in_vel_x,
  input  logic signed [31:0] in_vel_y,
  input  logic signed [31:0] in_box_min_x,
  input  logic signed [31:0] in_box_min_y,
  input  logic signed [31:0] in_box_max_x,
  input  logic signed [31:0] in_box_max_y,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic               out_is_hit,
  input  logic signed [31:0] out_entry_time,
  input  logic signed [1:0]  out_normal_x,
  input  logic signed [1:0]  out_normal_y,
  output int                 error_count,
  output int                 pending_count
);

  typedef struct packed {
    logic               is_hit;
    logic signed [31:0] entry_time;
    logic signed [1:0]  normal_x;
    logic signed [1:0]  normal_y;
  } hit_res_t;

  hit_res_t pending_hits[$];

  assign pending_count = pending_hits.size();

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Entry and exit times for one axis
  function automatic void axis_times(input longint c, input longint r, input longint v,
                                     input longint bmin, input longint bmax,
                                     output longint t_in, output longint t_out);
    longint lo, hi, a, b;
    lo = clamp32(bmin - r);
    hi = clamp32(bmax + r);
    if (v == 0) begin
      if (c >= lo && c <= hi) begin
        t_in = -64'sd2147483648;
        t_out = 64'sd2147483647;
      end else begin
        t_in = 64'sd2147483647;
        t_out = -64'sd2147483648;
      end
    end else begin
      a = clamp32(((lo - c) <<< FRAC_BITS) / v);
      b = clamp32(((hi - c) <<< FRAC_BITS) / v);
      if (v < 0) begin
        t_in = b;
        t_out = a;
      end else begin
        t_in = a;
        t_out = b;
      end
    end
  endfunction

  function automatic hit_res_t sweep_hit();
    hit_res_t res;
    longint inx, outx, iny, outy, entry, leave;
    axis_times(in_center_x, longint'(in_circle_radius), in_vel_x,
               in_box_min_x, in_box_max_x, inx, outx);
    axis_times(in_center_y, longint'(in_circle_radius), in_vel_y,
               in_box_min_y, in_box_max_y, iny, outy);
    entry = (inx > iny) ? inx : iny;
    leave = (outx < outy) ? outx : outy;
    res = '0;
    if (!(entry > leave || (inx < 0 && iny < 0))) begin
      res.is_hit = 1'b1;
      res.entry_time = entry[31:0];
      if (inx > iny) res.normal_x = (in_vel_x < 0) ? 2'sd1 : -2'sd1;
      else res.normal_y = (in_vel_y < 0) ? 2'sd1 : -2'sd1;
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    error_count++;
  endtask

  initial error_count = 0;

  always @(posedge clk) begin
    hit_res_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) pending_hits.push_back(sweep_hit());
      if (out_valid && !out_stall) begin
        if (pending_hits.size() == 0) begin
          report_mismatch("result with no request outstanding");
        end else begin
          want = pending_hits.pop_front();
          if (out_is_hit !== want.is_hit)
            report_mismatch($sformatf("is_hit %0d want %0d", out_is_hit, want.is_hit));
          if (out_entry_time !== want.entry_time)
            report_mismatch($sformatf("entry_time %0d want %0d", out_entry_time,
                                      want.entry_time));
          if (out_normal_x !== want.normal_x)
            report_mismatch($sformatf("normal_x %0d want %0d", out_normal_x,
                                      want.normal_x));
          if (out_normal_y !== want.normal_y)
            report_mismatch($sformatf("normal_y %0d want %0d", out_normal_y,
                                      want.normal_y));
        end
      end
    end
  end

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb : swept circle / box slab test bench
// Drives directed corner requests then random sweeps in bursts, stalls the
// result side on its own pattern and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb;

  localparam int N_RANDOM   = 1530;
  localparam int LATENCY    = 53;
  localparam int IDLE_LIMIT = 5000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [31:0] in_center_x = '0;
  logic signed [31:0] in_center_y = '0;
  logic        [30:0] in_circle_radius = '0;
  logic signed [31:0] in_vel_x = '0;
  logic signed [31:0] in_vel_y = '0;
  logic signed [31:0] in_box_min_x = '0;
  logic signed [31:0] in_box_min_y = '0;
  logic signed [31:0] in_box_max_x = '0;
  logic signed [31:0] in_box_max_y = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               out_is_hit;
  logic signed [31:0] out_entry_time;
  logic signed [1:0]  out_normal_x;
  logic signed [1:0]  out_normal_y;
  int                 error_count;
  int                 pending_count;
  int                 idle_cycles = 0;

  // 4 time unit period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  swept_circle_box_slab_test dut (.*);

  swept_circle_box_slab_test_checker chk (.*);

  // one query, fields in port order
  typedef struct {
    logic signed [31:0] cx, cy;
    logic        [30:0] r;
    logic signed [31:0] vx, vy, bx0, by0, bx1, by1;
  } sweep_req_t;

  // Watchdog: cycles with no accepted request or result
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Receiver stall pattern; one long hold-off early on freezes the pipe
  initial begin
    int mode;
    repeat (12) @(posedge clk);
    repeat (300) @(posedge clk);
    out_stall <= 1'b1;
    repeat (200) @(posedge clk);
    out_stall <= 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(5, 60)) begin
        @(posedge clk);
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 1) == 0);
          default: out_stall <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'sh8000_0000 + $urandom_range(0, 3);
      2: return 32'sh7FFF_FFFF - $urandom_range(0, 3);
      3: return 32'(signed'($urandom_range(0, 32'h3FF)) - 512);
      default: return 32'(signed'($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000);
    endcase
  endfunction

  // Random geometry: box ordered most of the time, sweep sometimes aimed at it
  function automatic sweep_req_t rand_req();
    sweep_req_t q;
    logic signed [31:0] t;
    q.cx = rand_coord(); q.cy = rand_coord();
    q.bx0 = rand_coord(); q.by0 = rand_coord();
    q.bx1 = rand_coord(); q.by1 = rand_coord();
    q.vx = ($urandom_range(0, 5) == 0) ? 32'sd0 : rand_coord();
    q.vy = ($urandom_range(0, 5) == 0) ? 32'sd0 : rand_coord();
    q.r = ($urandom_range(0, 7) == 0) ? 31'($urandom()) : 31'($urandom_range(0, 32'h3_FFFF));
    if ($urandom_range(0, 3) != 0) begin
      if (q.bx0 > q.bx1) begin t = q.bx0; q.bx0 = q.bx1; q.bx1 = t; end
      if (q.by0 > q.by1) begin t = q.by0; q.by0 = q.by1; q.by1 = t; end
      if ($urandom_range(0, 1) == 1) begin
        // aim the sweep at the box
        q.vx = (q.bx0 >>> 1) + (q.bx1 >>> 1) - (q.cx >>> 1);
        q.vy = (q.by0 >>> 1) + (q.by1 >>> 1) - (q.cy >>> 1);
      end
    end
    return q;
  endfunction

  task automatic send_req(input sweep_req_t q);
    in_valid <= 1'b1;
    in_center_x <= q.cx; in_center_y <= q.cy; in_circle_radius <= q.r;
    in_vel_x <= q.vx; in_vel_y <= q.vy;
    in_box_min_x <= q.bx0; in_box_min_y <= q.by0;
    in_box_max_x <= q.bx1; in_box_max_y <= q.by1;
    // hold until accepted
    do @(posedge clk); while (in_stall);
  endtask

  task automatic pause_input(input int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  function automatic sweep_req_t mk(input logic signed [31:0] cx, cy,
                                    input logic [30:0] r,
                                    input logic signed [31:0] vx, vy, bx0, by0, bx1, by1);
    sweep_req_t q;
    q.cx = cx; q.cy = cy; q.r = r; q.vx = vx; q.vy = vy;
    q.bx0 = bx0; q.by0 = by0; q.bx1 = bx1; q.by1 = by1;
    return q;
  endfunction

  initial begin
    sweep_req_t q;
    int burst;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: plain hit on x, hit on y, miss behind
    send_req(mk(-32'sh5_0000, 0, 31'h1_0000, 32'sh10_0000, 0,
                -32'sh1_0000, -32'sh1_0000, 32'sh1_0000, 32'sh1_0000));
    send_req(mk(0, 32'sh5_0000, 31'h1_0000, 0, -32'sh10_0000,
                -32'sh1_0000, -32'sh1_0000, 32'sh1_0000, 32'sh1_0000));
    send_req(mk(32'sh5_0000, 0, 0, 32'sh1_0000, 0,
                -32'sh1_0000, -32'sh1_0000, 32'sh1_0000, 32'sh1_0000));
    // zero velocity, inside both slabs: both entries negative, so a miss
    send_req(mk(0, 0, 0, 0, 0, -32'sh1_0000, -32'sh1_0000, 32'sh1_0000, 32'sh1_0000));
    // zero velocity on bounds exactly (inclusive) plus motion on y
    send_req(mk(32'sh1_0000, -32'sh4_0000, 0, 0, 32'sh8_0000,
                -32'sh1_0000, -32'sh1_0000, 32'sh1_0000, 32'sh1_0000));
    // zero velocity, outside slab
    send_req(mk(32'sh2_0000, -32'sh4_0000, 0, 0, 32'sh8_0000,
                -32'sh1_0000, -32'sh1_0000, 32'sh1_0000, 32'sh1_0000));
    // tie of entry times picks y
    send_req(mk(-32'sh2_0000, -32'sh2_0000, 0, 32'sh4_0000, 32'sh4_0000,
                -32'sh1_0000, -32'sh1_0000, 32'sh1_0000, 32'sh1_0000));
    // negative velocities on both axes
    send_req(mk(32'sh3_0000, 32'sh2_0000, 31'h8000, -32'sh6_0000, -32'sh2_0000,
                -32'sh1_0000, -32'sh1_0000, 32'sh1_0000, 32'sh1_0000));
    // inverted box
    send_req(mk(-32'sh5_0000, 0, 0, 32'sh10_0000, 0,
                32'sh1_0000, 32'sh1_0000, -32'sh1_0000, -32'sh1_0000));
    // radius maximum, bounds saturate
    send_req(mk(32'sh7FFF_FFFF, 32'sh8000_0000, 31'h7FFF_FFFF, 1, -1,
                32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
    // tiny velocity, quotient saturates
    send_req(mk(32'sh8000_0000, 0, 0, 1, 0, 32'sh7FFF_FFFF, -32'sh1_0000,
                32'sh7FFF_FFFF, 32'sh1_0000));
    // extreme velocities
    send_req(mk(32'sh8000_0000, 32'sh7FFF_FFFF, 0, 32'sh7FFF_FFFF, 32'sh8000_0000,
                0, 0, 32'sh1_0000, 32'sh1_0000));
    send_req(mk(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 31'h7FFF_FFFF, 32'sh8000_0000,
                32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                32'sh8000_0000));
    send_req(mk(32'hFFFF_FFFF, 32'hFFFF_FFFF, 31'h5555_5555, 32'hFFFF_FFFF,
                32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                32'hFFFF_FFFF));
    // entry exactly at zero
    send_req(mk(-32'sh1_0000, 0, 0, 32'sh1_0000, 0,
                -32'sh1_0000, -32'sh1_0000, 32'sh1_0000, 32'sh1_0000));

    // Random part in bursts with random gaps
    for (int i = 0; i < N_RANDOM; ) begin
      burst = $urandom_range(1, 40);
      for (int b = 0; b < burst && i < N_RANDOM; b++, i++) begin
        q = rand_req();
        send_req(q);
      end
      pause_input(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12));
    end
    in_valid <= 1'b0;

    while (pending_count != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
    if (error_count == 0 && pending_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
